FILE: design/cosine_angle_force_macros.svh
`ifndef COSINE_ANGLE_FORCE_MACROS_SVH
`define COSINE_ANGLE_FORCE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CAF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CAF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/caf_pkg.sv
package caf_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CNT_W      = 6;

	localparam logic [CNT_W-1:0] SQRT_STEPS  = 6'd32;
	localparam logic [CNT_W-1:0] E_DIV_STEPS = 6'd31;
	localparam logic [CNT_W-1:0] F_DIV_STEPS = 6'd50;

	// 1.0 in Q2.30, also the bond component limit
	localparam logic signed [33:0] ONE30 = 34'sd1073741824;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIODIC_ON,
		CFG_BOX_LEN_X,
		CFG_BOX_LEN_Y,
		CFG_BOX_LEN_Z,
		CFG_STIFFNESS_DEFAULT,
		CFG_USE_TYPE_STIFFNESS,
		CFG_STIFFNESS_TYPE_ONE,
		CFG_STIFFNESS_TYPE_TWO
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] apex_x;
		logic signed [31:0] apex_y;
		logic signed [31:0] apex_z;
		logic signed [31:0] third_x;
		logic signed [31:0] third_y;
		logic signed [31:0] third_z;
		logic [1:0]         angle_type;
		logic               start_of_set;
	} angle_t;

	typedef struct packed {
		logic signed [31:0] force_first_x;
		logic signed [31:0] force_first_y;
		logic signed [31:0] force_first_z;
		logic signed [31:0] force_apex_x;
		logic signed [31:0] force_apex_y;
		logic signed [31:0] force_apex_z;
		logic signed [31:0] force_third_x;
		logic signed [31:0] force_third_y;
		logic signed [31:0] force_third_z;
		logic [47:0]        energy_sum;
		logic               zero_bond;
	} result_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MUL,
		CMD_ACC,
		CMD_SQRT_INIT,
		CMD_SQRT_STEP,
		CMD_SQRT_SAVE,
		CMD_E_INIT,
		CMD_F_INIT,
		CMD_DIV_STEP,
		CMD_E_SAVE,
		CMD_F_SAVE,
		CMD_C_SET,
		CMD_ENERGY,
		CMD_W_SET,
		CMD_OUT
	} op_t;

	typedef enum logic [2:0] {
		MSEL_SQ,
		MSEL_DOT,
		MSEL_EN,
		MSEL_CE,
		MSEL_KW
	} msel_t;

	typedef struct packed {
		op_t        op;
		msel_t      msel;
		logic       vec;
		logic [1:0] comp;
	} cmd_t;

	typedef struct packed {
		logic zero_bond;
		logic out_free;
	} status_t;

	// wrap once into the box, then limit to +-1.0 (ONE30)
	function automatic logic signed [31:0] bond_comp(input logic signed [32:0] d,
			input logic [30:0] len, input logic periodic);
		logic signed [33:0] dd;
		logic signed [33:0] l;
		logic signed [33:0] t;
		dd = 34'(d);
		l  = 34'({1'b0, len});
		t  = dd;
		if (periodic) begin
			if ((dd <<< 1) > l) t = dd - l;
			else if ((dd <<< 1) < -l) t = dd + l;
		end
		if (t > ONE30) t = ONE30;
		else if (t < -ONE30) t = -ONE30;
		return t[31:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v > 53'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -53'sd2147483648) r = 32'sh80000000;
		return r;
	endfunction

endpackage

FILE: design/caf_angle_if.sv
interface caf_angle_if import caf_pkg::*; ();
	logic   valid;
	logic   ready;
	angle_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/caf_result_if.sv
interface caf_result_if import caf_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/cosine_angle_force.sv
// channel  direction  handshake            payload
// angle    in         valid/ready          three positions, angle_type, start_of_set
// result   out        valid/ready          nine forces, energy_sum, zero_bond
// cfg      in         cfg_we (no stall)    cfg_idx, cfg_data
//
// one angle at a time, taken only when idle; a zero-length bond skips the divisions;
// the work uses one shared 34x34 multiplier, a one-bit-per-cycle square root
// (32 steps, twice) and a one-bit-per-cycle divider (31 steps six times, 50 six times).
// arst_n clears the controller, the configuration registers, the energy sum and the result valid flag.
// the finished result sits in an output register, so a new angle is taken while it waits.
`include "cosine_angle_force_macros.svh"

module cosine_angle_force import caf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	caf_angle_if.sink             angle,
	caf_result_if.source          result
);

	cmd_t    cmd;
	status_t status;
	logic    ready;

	caf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (angle.valid),
		.in_ready (ready),
		.status   (status),
		.cmd      (cmd)
	);

	caf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_data   (angle.data),
		.cmd       (cmd),
		.status    (status),
		.res_data  (result.data),
		.res_valid (result.valid),
		.res_ready (result.ready)
	);

	assign angle.ready = ready;

	`CAF_ASSERT_NEXT(a_one_at_a_time, angle.valid && angle.ready, !angle.ready, "request taken while busy")
	`CAF_ASSERT_NOW(a_out_slot_free, cmd.op == CMD_OUT, status.out_free, "result register overwritten")
	`CAF_ASSERT_NOW(a_zero_forces, result.valid && result.data.zero_bond, result.data.force_first_x == 0 && result.data.force_apex_y == 0 && result.data.force_third_z == 0, "zero bond with force")

endmodule

FILE: design/caf_datapath.sv
module caf_datapath import caf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  angle_t                in_data,
	input  cmd_t                  cmd,
	output status_t               status,
	output result_t               res_data,
	output logic                  res_valid,
	input  logic                  res_ready
);

	logic        periodic_q;
	logic [30:0] box_q [3];
	logic [31:0] k_def_q, k_one_q, k_two_q;
	logic        use_type_q;
	logic [47:0] energy_q;

	logic signed [31:0] d_q [2][3];
	logic signed [31:0] e_q [2][3];
	logic signed [50:0] f_q [2][3];
	logic [31:0]        r_q [2];
	logic [31:0]        k_q;
	logic signed [65:0] prod_q, acc_q;
	logic [63:0]        sx_q, sr_q, sb_q;
	logic [31:0]        rem_q, den_q;
	logic [63:0]        num_q;
	logic [49:0]        quo_q;
	logic               neg_q;
	logic signed [31:0] c_q;
	logic signed [32:0] w_q;
	result_t            res_q;
	logic               res_valid_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [65:0] c_trunc, w_trunc, p_mag;
	logic signed [31:0] c_next;
	logic [63:0]        sq_sum;
	logic [32:0]        div_t;
	logic               div_ge;
	logic [30:0]        d_mag;
	logic [63:0]        e_dividend;
	logic signed [50:0] q_signed;
	logic [33:0]        en_term;
	logic [48:0]        en_sum;
	logic               zero;

	assign zero = (r_q[0] == '0) || (r_q[1] == '0);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.msel)
			MSEL_SQ: begin
				mul_a = 34'(d_q[cmd.vec][cmd.comp]);
				mul_b = 34'(d_q[cmd.vec][cmd.comp]);
			end
			MSEL_DOT: begin
				mul_a = 34'(e_q[0][cmd.comp]);
				mul_b = 34'(e_q[1][cmd.comp]);
			end
			MSEL_EN: begin
				mul_a = 34'({1'b0, k_q});
				mul_b = 34'(c_q) + ONE30;
			end
			MSEL_CE: begin
				mul_a = 34'(c_q);
				mul_b = 34'(e_q[cmd.vec][cmd.comp]);
			end
			MSEL_KW: begin
				mul_a = 34'({1'b0, k_q});
				mul_b = 34'(w_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divide by 2^30 truncating toward zero
	always_comb begin
		c_trunc = (acc_q + (acc_q[65] ? 66'sd1073741823 : 66'sd0)) >>> 30;
		w_trunc = (prod_q + (prod_q[65] ? 66'sd1073741823 : 66'sd0)) >>> 30;
		if (c_trunc > 66'(ONE30)) c_next = ONE30[31:0];
		else if (c_trunc < -66'(ONE30)) c_next = -ONE30[31:0];
		else c_next = c_trunc[31:0];
		p_mag = prod_q[65] ? -prod_q : prod_q;
	end

	always_comb begin
		sq_sum     = sr_q + sb_q;
		div_t      = {rem_q, num_q[63]};
		div_ge     = div_t >= {1'b0, den_q};
		d_mag      = d_q[cmd.vec][cmd.comp][31] ? 31'(-d_q[cmd.vec][cmd.comp])
				: d_q[cmd.vec][cmd.comp][30:0];
		e_dividend = 64'({d_mag, 30'b0});
		q_signed   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		en_term    = prod_q[63:30];
		en_sum     = {1'b0, energy_q} + 49'(en_term);
	end

	// configuration and running energy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periodic_q <= 1'b0;
			box_q[0]   <= '0;
			box_q[1]   <= '0;
			box_q[2]   <= '0;
			k_def_q    <= '0;
			use_type_q <= 1'b0;
			k_one_q    <= '0;
			k_two_q    <= '0;
			energy_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_PERIODIC_ON:        periodic_q <= cfg_data[0];
					CFG_BOX_LEN_X:          box_q[0]   <= cfg_data[30:0];
					CFG_BOX_LEN_Y:          box_q[1]   <= cfg_data[30:0];
					CFG_BOX_LEN_Z:          box_q[2]   <= cfg_data[30:0];
					CFG_STIFFNESS_DEFAULT:  k_def_q    <= cfg_data;
					CFG_USE_TYPE_STIFFNESS: use_type_q <= cfg_data[0];
					CFG_STIFFNESS_TYPE_ONE: k_one_q    <= cfg_data;
					CFG_STIFFNESS_TYPE_TWO: k_two_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == CMD_LOAD && in_data.start_of_set) begin
				energy_q <= '0;
			end else if (cmd.op == CMD_ENERGY) begin
				energy_q <= en_sum[48] ? 48'hFFFF_FFFF_FFFF : en_sum[47:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: begin
				d_q[0][0] <= bond_comp(33'(in_data.first_x) - 33'(in_data.apex_x),
						box_q[0], periodic_q);
				d_q[0][1] <= bond_comp(33'(in_data.first_y) - 33'(in_data.apex_y),
						box_q[1], periodic_q);
				d_q[0][2] <= bond_comp(33'(in_data.first_z) - 33'(in_data.apex_z),
						box_q[2], periodic_q);
				d_q[1][0] <= bond_comp(33'(in_data.third_x) - 33'(in_data.apex_x),
						box_q[0], periodic_q);
				d_q[1][1] <= bond_comp(33'(in_data.third_y) - 33'(in_data.apex_y),
						box_q[1], periodic_q);
				d_q[1][2] <= bond_comp(33'(in_data.third_z) - 33'(in_data.apex_z),
						box_q[2], periodic_q);
				if (use_type_q) k_q <= (in_data.angle_type == 2'd2) ? k_two_q : k_one_q;
				else k_q <= k_def_q;
				acc_q <= '0;
			end
			CMD_MUL: prod_q <= mul_a * mul_b;
			CMD_ACC: acc_q <= acc_q + prod_q;
			CMD_SQRT_INIT: begin
				sx_q <= acc_q[63:0];
				sr_q <= '0;
				sb_q <= 64'h4000_0000_0000_0000;
			end
			CMD_SQRT_STEP: begin
				if (sx_q >= sq_sum) begin
					sx_q <= sx_q - sq_sum;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end
			CMD_SQRT_SAVE: begin
				r_q[cmd.vec] <= sr_q[31:0];
				acc_q        <= '0;
			end
			CMD_E_INIT: begin
				rem_q <= e_dividend[62:31];
				num_q <= {e_dividend[30:0], 33'b0};
				quo_q <= '0;
				neg_q <= d_q[cmd.vec][cmd.comp][31];
				den_q <= r_q[cmd.vec];
			end
			CMD_F_INIT: begin
				rem_q <= '0;
				num_q <= {p_mag[63:14], 14'b0};
				quo_q <= '0;
				neg_q <= prod_q[65];
				den_q <= r_q[cmd.vec];
			end
			CMD_DIV_STEP: begin
				rem_q <= div_ge ? 32'(div_t - {1'b0, den_q}) : div_t[31:0];
				quo_q <= {quo_q[48:0], div_ge};
				num_q <= num_q << 1;
			end
			CMD_E_SAVE: e_q[cmd.vec][cmd.comp] <= q_signed[31:0];
			CMD_F_SAVE: f_q[cmd.vec][cmd.comp] <= q_signed;
			CMD_C_SET: c_q <= c_next;
			CMD_W_SET: w_q <= 33'(w_trunc) - 33'(e_q[~cmd.vec][cmd.comp]);
			CMD_OUT: begin
				res_q.force_first_x <= zero ? '0 : sat32(53'(f_q[0][0]));
				res_q.force_first_y <= zero ? '0 : sat32(53'(f_q[0][1]));
				res_q.force_first_z <= zero ? '0 : sat32(53'(f_q[0][2]));
				res_q.force_third_x <= zero ? '0 : sat32(53'(f_q[1][0]));
				res_q.force_third_y <= zero ? '0 : sat32(53'(f_q[1][1]));
				res_q.force_third_z <= zero ? '0 : sat32(53'(f_q[1][2]));
				res_q.force_apex_x  <= zero ? '0
						: sat32(-(53'(f_q[0][0]) + 53'(f_q[1][0])));
				res_q.force_apex_y  <= zero ? '0
						: sat32(-(53'(f_q[0][1]) + 53'(f_q[1][1])));
				res_q.force_apex_z  <= zero ? '0
						: sat32(-(53'(f_q[0][2]) + 53'(f_q[1][2])));
				res_q.energy_sum    <= energy_q;
				res_q.zero_bond     <= zero;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.op == CMD_OUT) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign status.zero_bond = zero;
	assign status.out_free  = !res_valid_q || res_ready;
	assign res_data         = res_q;
	assign res_valid        = res_valid_q;

endmodule

FILE: design/caf_ctrl.sv
module caf_ctrl import caf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQ_MUL,
		S_SQ_ACC,
		S_SQRT_INIT,
		S_SQRT_STEP,
		S_SQRT_SAVE,
		S_CHECK,
		S_E_INIT,
		S_E_STEP,
		S_E_SAVE,
		S_DOT_MUL,
		S_DOT_ACC,
		S_C_SET,
		S_EN_MUL,
		S_EN_ADD,
		S_CE_MUL,
		S_W_SET,
		S_KW_MUL,
		S_F_INIT,
		S_F_STEP,
		S_F_SAVE,
		S_OUT
	} state_t;

	state_t           state_q;
	logic             vec_q;
	logic [1:0]       comp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_six;

	assign last_six = vec_q && (comp_q == 2'd2);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op   = CMD_NONE;
		cmd.msel = MSEL_SQ;
		cmd.vec  = vec_q;
		cmd.comp = comp_q;
		case (state_q)
			S_IDLE:      cmd.op = in_valid ? CMD_LOAD : CMD_NONE;
			S_SQ_MUL:    cmd.op = CMD_MUL;
			S_SQ_ACC:    cmd.op = CMD_ACC;
			S_SQRT_INIT: cmd.op = CMD_SQRT_INIT;
			S_SQRT_STEP: cmd.op = CMD_SQRT_STEP;
			S_SQRT_SAVE: cmd.op = CMD_SQRT_SAVE;
			S_E_INIT:    cmd.op = CMD_E_INIT;
			S_E_STEP:    cmd.op = CMD_DIV_STEP;
			S_E_SAVE:    cmd.op = CMD_E_SAVE;
			S_DOT_MUL: begin
				cmd.op   = CMD_MUL;
				cmd.msel = MSEL_DOT;
			end
			S_DOT_ACC:   cmd.op = CMD_ACC;
			S_C_SET:     cmd.op = CMD_C_SET;
			S_EN_MUL: begin
				cmd.op   = CMD_MUL;
				cmd.msel = MSEL_EN;
			end
			S_EN_ADD:    cmd.op = CMD_ENERGY;
			S_CE_MUL: begin
				cmd.op   = CMD_MUL;
				cmd.msel = MSEL_CE;
			end
			S_W_SET:     cmd.op = CMD_W_SET;
			S_KW_MUL: begin
				cmd.op   = CMD_MUL;
				cmd.msel = MSEL_KW;
			end
			S_F_INIT:    cmd.op = CMD_F_INIT;
			S_F_STEP:    cmd.op = CMD_DIV_STEP;
			S_F_SAVE:    cmd.op = CMD_F_SAVE;
			S_OUT:       cmd.op = status.out_free ? CMD_OUT : CMD_NONE;
			default:     cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vec_q   <= 1'b0;
			comp_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SQ_MUL;
						vec_q   <= 1'b0;
						comp_q  <= '0;
					end
				end
				S_SQ_MUL: state_q <= S_SQ_ACC;
				S_SQ_ACC: begin
					if (comp_q == 2'd2) begin
						comp_q  <= '0;
						state_q <= S_SQRT_INIT;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= S_SQ_MUL;
					end
				end
				S_SQRT_INIT: begin
					cnt_q   <= '0;
					state_q <= S_SQRT_STEP;
				end
				S_SQRT_STEP: begin
					if (cnt_q == SQRT_STEPS - 1'b1) state_q <= S_SQRT_SAVE;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_SQRT_SAVE: begin
					if (vec_q) begin
						vec_q   <= 1'b0;
						state_q <= S_CHECK;
					end else begin
						vec_q   <= 1'b1;
						state_q <= S_SQ_MUL;
					end
				end
				S_CHECK: state_q <= status.zero_bond ? S_OUT : S_E_INIT;
				S_E_INIT: begin
					cnt_q   <= '0;
					state_q <= S_E_STEP;
				end
				S_E_STEP: begin
					if (cnt_q == E_DIV_STEPS - 1'b1) state_q <= S_E_SAVE;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_E_SAVE: begin
					if (last_six) begin
						vec_q   <= 1'b0;
						comp_q  <= '0;
						state_q <= S_DOT_MUL;
					end else begin
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							vec_q  <= ~vec_q;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
						state_q <= S_E_INIT;
					end
				end
				S_DOT_MUL: state_q <= S_DOT_ACC;
				S_DOT_ACC: begin
					if (comp_q == 2'd2) begin
						comp_q  <= '0;
						state_q <= S_C_SET;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= S_DOT_MUL;
					end
				end
				S_C_SET:  state_q <= S_EN_MUL;
				S_EN_MUL: state_q <= S_EN_ADD;
				S_EN_ADD: state_q <= S_CE_MUL;
				S_CE_MUL: state_q <= S_W_SET;
				S_W_SET:  state_q <= S_KW_MUL;
				S_KW_MUL: state_q <= S_F_INIT;
				S_F_INIT: begin
					cnt_q   <= '0;
					state_q <= S_F_STEP;
				end
				S_F_STEP: begin
					if (cnt_q == F_DIV_STEPS - 1'b1) state_q <= S_F_SAVE;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_F_SAVE: begin
					if (last_six) begin
						state_q <= S_OUT;
					end else begin
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							vec_q  <= ~vec_q;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
						state_q <= S_CE_MUL;
					end
				end
				S_OUT: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
